[rtl/acia_pkg.sv]
// Shared types and constants for the serial adapter register model.
package acia_pkg;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2
    } acia_action_t;

    localparam logic SEL_CTRL_STATUS = 1'b0;
    localparam logic SEL_DATA        = 1'b1;

    localparam logic [7:0] ST_RX_FULL   = 8'h01;
    localparam logic [7:0] ST_TX_EMPTY  = 8'h02;
    localparam logic [7:0] ST_OVERRUN   = 8'h20;
    localparam logic [7:0] ST_IRQ       = 8'h80;
    localparam logic [7:0] ST_IRQ_CLEAR = 8'h7F;
    localparam logic [7:0] ST_RX_CLEAR  = 8'h21;

    localparam logic [7:0] CTL_RX_IRQ_EN   = 8'h80;
    localparam logic [7:0] CTL_TX_MODE     = 8'h60;
    localparam logic [7:0] CTL_TX_IRQ_MODE = 8'h20;
    localparam logic [1:0] CTL_MASTER_RST  = 2'b11;

    typedef struct packed {
        logic [1:0] action;
        logic       reg_select;
        logic [7:0] write_data;
        logic       line_rx_ready;
        logic       line_tx_ready;
        logic [7:0] line_rx_byte;
    } acia_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic       tx_strobe;
        logic [7:0] tx_byte;
    } acia_result_t;

endpackage

[rtl/acia_uart_register_model_unit.sv]
// Top level of the serial adapter register model: request and response pipeline.
//
// Usage:
//   The req channel carries one word per bus read, bus write or line tick
//   (req_valid / req_stall / req). The rsp channel returns exactly one
//   result word per request (rsp_valid / rsp_stall / rsp): read data, the
//   interrupt level after the request, and a transmit strobe with its byte.
//   A request is taken when req_valid is high and req_stall is low; a
//   result is taken when rsp_valid is high and rsp_stall is low.
// Pipeline: a request taken is held in the input register, and its result
//   then moves into the result register, where rsp_valid marks it until it
//   is taken; a stall on rsp_stall can hold the word in either register.
// Throughput: one word per cycle when nothing stalls. The register state is
//   updated in the same cycle that a word moves from the input register to
//   the result register; the update is a handful of flag operations.
// Reset: rst_n clears both pipeline stages and puts status at transmit
//   empty with control, receive data and master reset cleared.
// Stall: while rsp_stall holds a result, the word in the input register
//   waits; req_stall rises only when that input register is occupied and
//   cannot advance, so one new word is still taken behind a stalled result.
module acia_uart_register_model_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  acia_pkg::acia_item_t   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output acia_pkg::acia_result_t rsp
);
    import acia_pkg::*;

    acia_item_t   item_reg;
    logic         item_valid_reg;
    logic         item_valid_next;
    acia_result_t result_reg;
    acia_result_t core_result;
    logic         result_valid_reg;
    logic         result_valid_next;
    logic         advance;
    logic         accept;

    // Move the held word forward when the result slot is free or draining.
    assign advance   = item_valid_reg && (!result_valid_reg || !rsp_stall);
    assign req_stall = item_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    acia_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !rsp_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Hold control state under reset; payload registers load on their enables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign rsp_valid = result_valid_reg;
    assign rsp       = result_reg;

    advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced word did not land in the result register");

    stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (item_valid_reg && result_valid_reg && rsp_stall))
        else $error("request stalled with room in the pipeline");

    accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_valid_reg)
        else $error("accepted word lost from the input register");

endmodule

[rtl/acia_core.sv]
// Adapter register state and the single-pass update for one word.
module acia_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  acia_pkg::acia_item_t item,
    output acia_pkg::acia_result_t result
);
    import acia_pkg::*;

    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic [7:0] control_reg;
    logic [7:0] control_next;
    logic [7:0] rx_holding_reg;
    logic [7:0] rx_holding_next;
    logic       master_rst_reg;
    logic       master_rst_next;

    // Fold the interrupt request into status bit 7.
    function automatic logic [7:0] with_irq(input logic [7:0] st, input logic [7:0] ctl);
        logic req;
        req = ((st & ST_RX_FULL) != 8'h00 && (ctl & CTL_RX_IRQ_EN) != 8'h00)
            || ((st & ST_TX_EMPTY) != 8'h00 && (ctl & CTL_TX_MODE) == CTL_TX_IRQ_MODE);
        return req ? ((st & ST_IRQ_CLEAR) | ST_IRQ) : (st & ST_IRQ_CLEAR);
    endfunction

    always_comb
    begin
        logic [7:0] st;
        status_next      = status_reg;
        control_next     = control_reg;
        rx_holding_next  = rx_holding_reg;
        master_rst_next  = master_rst_reg;
        st               = status_reg;
        result.read_data = 8'h00;
        result.tx_strobe = 1'b0;
        result.tx_byte   = 8'h00;
        case (item.action)
            ACT_READ:
            begin
                if (item.reg_select == SEL_CTRL_STATUS)
                begin
                    result.read_data = master_rst_reg ? 8'h00 : status_reg;
                end
                else
                begin
                    status_next      = with_irq(status_reg & ~ST_RX_CLEAR, control_reg);
                    result.read_data = rx_holding_reg;
                end
            end
            ACT_WRITE:
            begin
                if (item.reg_select == SEL_CTRL_STATUS)
                begin
                    control_next = item.write_data;
                    if (item.write_data[1:0] == CTL_MASTER_RST)
                    begin
                        master_rst_next = 1'b1;
                    end
                    else if (master_rst_reg)
                    begin
                        master_rst_next = 1'b0;
                        st              = ST_TX_EMPTY;
                    end
                    status_next = with_irq(st, item.write_data);
                end
                else
                begin
                    result.tx_strobe = 1'b1;
                    result.tx_byte   = item.write_data;
                    status_next      = with_irq(status_reg & ~ST_TX_EMPTY, control_reg);
                end
            end
            ACT_TICK:
            begin
                if (item.line_rx_ready && !master_rst_reg)
                begin
                    if ((st & ST_RX_FULL) != 8'h00)
                    begin
                        st = st | ST_OVERRUN;
                    end
                    rx_holding_next = item.line_rx_byte;
                    st              = st | ST_RX_FULL;
                end
                if (item.line_tx_ready)
                begin
                    st = st | ST_TX_EMPTY;
                end
                status_next = with_irq(st, control_reg);
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
        // Status bit 7 always carries the request level.
        result.irq_out = status_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= ST_TX_EMPTY;
            control_reg    <= 8'h00;
            rx_holding_reg <= 8'h00;
            master_rst_reg <= 1'b0;
        end
        else if (step)
        begin
            status_reg     <= status_next;
            control_reg    <= control_next;
            rx_holding_reg <= rx_holding_next;
            master_rst_reg <= master_rst_next;
        end
    end

    irq_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[7] == ((status_reg[0] && control_reg[7])
                          || (status_reg[1] && control_reg[6:5] == 2'b01)))
        else $error("irq bit out of step with status and control");

    master_rst_needs_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        master_rst_reg |-> control_reg[1:0] == CTL_MASTER_RST)
        else $error("master reset held without control bits 1:0 set");

    overrun_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[5] |-> status_reg[0])
        else $error("overrun flagged with receive register empty");

endmodule

[tb/sv/acia_uart_register_model_unit_test.sv]
// Self-checking testbench for the serial adapter register model unit.
module acia_uart_register_model_unit_test;

    import acia_pkg::*;

    // The package gives no name to the spare action code; the block must
    // treat it as a no-op that still reports the interrupt level.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_WORDS  = 1800;
    // Receiver hold-off: stall the result side for a long run while the
    // sender keeps offering words, so both pipeline stages fill up.
    localparam int HOLD_START    = 1200;
    localparam int HOLD_CYCLES   = 150;
    // Two pipeline stages; a drain period after the last result catches stray results.
    localparam int DRAIN_CYCLES  = 10;
    // Longest legal quiet stretch is the hold-off plus a sender gap; take
    // it many times over.
    localparam int WATCHDOG_LIMIT = 4000;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_stall;
    acia_item_t   req       = '0;
    logic         rsp_valid;
    logic         rsp_stall = 1'b0;
    acia_result_t rsp;

    acia_uart_register_model_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Register image of the adapter, advanced once per accepted word.
    // ------------------------------------------------------------------
    logic [7:0] status_q   = ST_TX_EMPTY;
    logic [7:0] control_q  = 8'h00;
    logic [7:0] rx_hold_q  = 8'h00;
    logic       in_mreset  = 1'b0;
    logic       irq_q      = 1'b0;

    acia_item_t   pending_words[$];
    acia_result_t expected_results[$];
    int           accepted_words = 0;
    int           total_words    = 0;
    int           mismatches     = 0;

    // Recompute the interrupt level and mirror it into status bit 7.
    // The transmit request does not need control bit 7.
    function automatic void refresh_irq();
        logic rx_req;
        logic tx_req;
        rx_req = ((status_q & ST_RX_FULL) != 0) && ((control_q & CTL_RX_IRQ_EN) != 0);
        tx_req = ((status_q & ST_TX_EMPTY) != 0)
                 && ((control_q & CTL_TX_MODE) == CTL_TX_IRQ_MODE);
        irq_q    = rx_req || tx_req;
        status_q = status_q & ST_IRQ_CLEAR;
        if (irq_q)
            status_q = status_q | ST_IRQ;
    endfunction

    // Apply one bus access or line tick to the register image and return
    // the result word the block owes for it.
    function automatic acia_result_t acia_predict(input acia_item_t w);
        acia_result_t r;
        r = '0;
        case (w.action)
            ACT_READ:
                if (w.reg_select == SEL_CTRL_STATUS) begin
                    // Status reads as zero while master reset holds.
                    r.read_data = in_mreset ? 8'h00 : status_q;
                end
                else begin
                    // Data read clears full and overrun, even in master reset.
                    status_q = status_q & ~ST_RX_CLEAR;
                    refresh_irq();
                    r.read_data = rx_hold_q;
                end
            ACT_WRITE:
                if (w.reg_select == SEL_CTRL_STATUS) begin
                    control_q = w.write_data;
                    if (control_q[1:0] == CTL_MASTER_RST) begin
                        in_mreset = 1'b1;
                    end
                    else if (in_mreset) begin
                        // Leaving master reset restarts status at transmit empty.
                        in_mreset = 1'b0;
                        status_q  = ST_TX_EMPTY;
                    end
                    refresh_irq();
                end
                else begin
                    // Data write goes to the line even during master reset.
                    r.tx_strobe = 1'b1;
                    r.tx_byte   = w.write_data;
                    status_q    = status_q & ~ST_TX_EMPTY;
                    refresh_irq();
                end
            ACT_TICK: begin
                if (w.line_rx_ready && !in_mreset) begin
                    if ((status_q & ST_RX_FULL) != 0)
                        status_q = status_q | ST_OVERRUN;
                    rx_hold_q = w.line_rx_byte;
                    status_q  = status_q | ST_RX_FULL;
                end
                if (w.line_tx_ready)
                    status_q = status_q | ST_TX_EMPTY;
                refresh_irq();
            end
            default: ;
        endcase
        r.irq_out = irq_q;
        return r;
    endfunction

    function automatic acia_item_t make_word(input logic [1:0] act, input logic sel,
                                             input logic [7:0] wdata, input logic rx_rdy,
                                             input logic tx_rdy, input logic [7:0] rx_byte);
        acia_item_t w;
        w.action        = act;
        w.reg_select    = sel;
        w.write_data    = wdata;
        w.line_rx_ready = rx_rdy;
        w.line_tx_ready = tx_rdy;
        w.line_rx_byte  = rx_byte;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got 0x%02h, want 0x%02h (word %0d)",
                 what, got, want, accepted_words);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words in bursts of random length separated by random
    // gaps. Hold a stalled word unchanged; predict on acceptance so the
    // register image advances in the order the block sees the words.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else begin
            if (req_valid && !req_stall) begin
                expected_results.push_back(acia_predict(req));
                accepted_words++;
            end
            if (req_valid && req_stall) begin
                // hold the word until the block takes it
            end
            else if (gap_left != 0) begin
                req_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pending_words.size() != 0) begin
                req_valid <= 1'b1;
                req       <= pending_words.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    // A third of the bursts run back to back with no gap.
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left <= 0;
                        5:       gap_left <= $urandom_range(9, 20);
                        default: gap_left <= $urandom_range(1, 8);
                    endcase
                end
                else begin
                    burst_left <= burst_left - 1;
                end
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on its own pattern. Each segment picks a mode (free
    // running, light stall, heavy stall, alternate) for a random length.
    // One fixed window holds the stall high throughout.
    // ------------------------------------------------------------------
    int rx_cycles  = 0;
    int seg_left   = 0;
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            rx_cycles  <= 0;
            seg_left   <= 0;
            stall_mode <= 0;
        end
        else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES) begin
                rsp_stall <= 1'b1;
            end
            else if (seg_left == 0) begin
                seg_left   <= $urandom_range(8, 64);
                stall_mode <= $urandom_range(0, 3);
                rsp_stall  <= 1'b0;
            end
            else begin
                seg_left <= seg_left - 1;
                case (stall_mode)
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    3:       rsp_stall <= ~rsp_stall;
                    default: rsp_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        acia_result_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected", rsp.read_data, 8'h00);
            end
            else begin
                want = expected_results.pop_front();
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", rsp.read_data, want.read_data);
                if (rsp.irq_out !== want.irq_out)
                    report_mismatch("irq_out", {7'd0, rsp.irq_out}, {7'd0, want.irq_out});
                if (rsp.tx_strobe !== want.tx_strobe)
                    report_mismatch("tx_strobe", {7'd0, rsp.tx_strobe},
                                    {7'd0, want.tx_strobe});
                if (rsp.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", rsp.tx_byte, want.tx_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves a word for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", quiet_cycles);
                $display("acia_uart_register_model_unit_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed words first, then random traffic.
    // ------------------------------------------------------------------
    initial begin
        int         kind;
        logic       r_sel;
        logic [7:0] r_wdata;
        logic       r_rx;
        logic       r_tx;
        logic [7:0] r_rxbyte;

        // Directed part: reset state, both interrupt sources, overrun,
        // every master reset corner, the spare action code, field extremes.
        pending_words.push_back(make_word(ACT_READ,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_DATA,        8'hFF, 1'b1, 1'b1, 8'hFF));
        // transmit interrupt mode with transmit empty raises the request
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'h20, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_WRITE, SEL_DATA,        8'hFF, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_TICK,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b1, 8'h00));
        // receive interrupt enable, then two bytes in a row for overrun
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'h80, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_TICK,  SEL_DATA,        8'h00, 1'b1, 1'b0, 8'hA5));
        pending_words.push_back(make_word(ACT_TICK,  SEL_CTRL_STATUS, 8'h00, 1'b1, 1'b1, 8'h5A));
        pending_words.push_back(make_word(ACT_READ,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_DATA,        8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_TICK,  SEL_CTRL_STATUS, 8'h00, 1'b1, 1'b0, 8'hFF));
        // master reset: status reads zero, line bytes ignored, data still flows
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'h03, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_TICK,  SEL_CTRL_STATUS, 8'h00, 1'b1, 1'b1, 8'h11));
        pending_words.push_back(make_word(ACT_WRITE, SEL_DATA,        8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_DATA,        8'h00, 1'b0, 1'b0, 8'h00));
        // leave master reset: status restarts at transmit empty
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'hFC, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));
        // spare action code with every other field at its top value
        pending_words.push_back(make_word(ACT_UNUSED, SEL_DATA,       8'hFF, 1'b1, 1'b1, 8'hFF));
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'hFF, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_TICK,  SEL_DATA,        8'hFF, 1'b1, 1'b1, 8'h00));
        pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, 8'hA1, 1'b0, 1'b0, 8'h00));
        pending_words.push_back(make_word(ACT_READ,  SEL_CTRL_STATUS, 8'h00, 1'b0, 1'b0, 8'h00));

        // Random part: mostly reads, writes and ticks in a realistic mix,
        // with random noise on the fields the action ignores.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            kind     = $urandom_range(0, 99);
            r_sel    = 1'($urandom_range(0, 1));
            r_wdata  = 8'($urandom_range(0, 255));
            r_rx     = 1'($urandom_range(0, 1));
            r_tx     = 1'($urandom_range(0, 1));
            r_rxbyte = 8'($urandom_range(0, 255));
            if (kind < 28)
                pending_words.push_back(make_word(ACT_READ, r_sel, r_wdata, r_rx, r_tx,
                                                  r_rxbyte));
            else if (kind < 40)
                pending_words.push_back(make_word(ACT_WRITE, SEL_CTRL_STATUS, r_wdata, r_rx,
                                                  r_tx, r_rxbyte));
            else if (kind < 56)
                pending_words.push_back(make_word(ACT_WRITE, SEL_DATA, r_wdata, r_rx, r_tx,
                                                  r_rxbyte));
            else if (kind < 97)
                pending_words.push_back(make_word(ACT_TICK, r_sel, r_wdata, r_rx, r_tx,
                                                  r_rxbyte));
            else
                pending_words.push_back(make_word(ACT_UNUSED, r_sel, r_wdata, r_rx, r_tx,
                                                  r_rxbyte));
        end
        total_words = pending_words.size();

        // Hold reset at the start, then release it once.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every result to come back.
        while (accepted_words < total_words)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("acia_uart_register_model_unit_test: PASS");
        else
            $display("acia_uart_register_model_unit_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/acia_pkg.sv
rtl/acia_core.sv
rtl/acia_uart_register_model_unit.sv
tb/sv/acia_uart_register_model_unit_test.sv
